// ===== design/uslp_frame_sync_vcid_length_core_macros.svh =====
// ----------------------------------------------------------------------------
// USLP frame sync assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef USLP_FRAME_SYNC_VCID_LENGTH_CORE_MACROS_SVH
`define USLP_FRAME_SYNC_VCID_LENGTH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USLP_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USLP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/uslp_pkg.sv =====
// ----------------------------------------------------------------------------
// USLP frame sync package
// Field widths, table limits, register indexes and the output queue entry.
// ----------------------------------------------------------------------------
package uslp_pkg;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int CHAN_W   = 6;
    localparam int LEN_W    = 12;
    localparam int FV_W     = 4;
    localparam int SCID_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Stream bus widths.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    // Table and frame limits.
    localparam int CHANNEL_COUNT   = 64;
    localparam int TABLE_DEPTH     = 64;
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int HEADER_BYTES    = 4;

    // Output queue.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Reset values of the configuration registers.
    localparam logic [FV_W-1:0]   FV_RESET   = 4'd12;
    localparam logic [SCID_W-1:0] SCID_RESET = 16'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_VERSION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACECRAFT_ID = 1'd1;

    // Input command codes.
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_TABLE = 1'b1;

    // Output kind codes.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_SKIP  = 1'b1;

    // One queue entry: a single result, or the four header bytes as a burst.
    typedef struct packed {
        logic                        kind;
        logic                        last;
        logic [1:0]                  cnt_m1;
        logic [CHAN_W-1:0]           chan;
        logic [3:0][BYTE_W-1:0]      bytes;
    } t_entry;

endpackage

// ===== design/uslp_frame_sync_vcid_length_core.sv =====
// ----------------------------------------------------------------------------
// USLP frame sync with per-channel length table
// Hunts a byte stream for the version and spacecraft id marker, looks up the
// virtual channel's frame length and passes the located frame on.
// ----------------------------------------------------------------------------
// The block accepts one input item per clock while the output queue has room.
// A data item's table read is issued from the length memory in the cycle it
// is accepted, and the item is resolved in the next cycle, where it updates
// the hunting window and frame counters and writes at most one entry into a
// four-entry output queue; a table command item writes the memory at
// acceptance. Each entry leaves as one output item per cycle while the
// output is ready, except a located header, which leaves as four; so the
// input stalls when the queue has no room, as while a header burst drains or
// the output holds back. The table is cleared at reset through per-entry
// valid bits, with no clearing pass.
`include "uslp_frame_sync_vcid_length_core_macros.svh"

module uslp_frame_sync_vcid_length_core
    import uslp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [7:0] data_byte, [13:8] table_channel, [25:14] table_length, [31:26] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] command
    input  logic                  i_s_axis_tuser,
    // Output stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [7:0] frame_byte, [13:8] channel, [15:14] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // [0] kind
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tlast
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(HEADER_BYTES);

    // Input fields.
    logic [BYTE_W-1:0] in_byte;
    logic [CHAN_W-1:0] in_chan;
    logic [LEN_W-1:0]  in_len;
    logic              in_acc;

    assign in_byte = i_s_axis_tdata[7:0];
    assign in_chan = i_s_axis_tdata[13:8];
    assign in_len  = i_s_axis_tdata[25:14];
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers.
    logic [FV_W-1:0]   r_fv;
    logic [SCID_W-1:0] r_scid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv   <= FV_RESET;
            r_scid <= SCID_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                REG_FRAME_VERSION: r_fv   <= i_cfg_wdata[FV_W-1:0];
                REG_SPACECRAFT_ID: r_scid <= i_cfg_wdata[SCID_W-1:0];
                default: ;
            endcase
        end
    end

    // Architectural hunting and frame state, as left by the resolved items.
    logic [23:0]       r_win,    n_win;
    logic [1:0]        r_fill,   n_fill;
    logic              r_in_frame, n_in_frame;
    logic [LEN_W-1:0]  r_left,   n_left;
    logic [CHAN_W-1:0] r_cur_ch, n_cur_ch;

    // Resolve stage: the item accepted in the previous cycle.
    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [BYTE_W-1:0] r_s1_byte;

    // Length table and its valid bits.
    logic [LEN_W-1:0]       r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_tvalid;
    logic [LEN_W-1:0]       r_rd_data;
    logic                   r_rd_valid;
    logic [CHAN_W-1:0]      rd_addr;
    logic [BYTE_W-1:0]      eff_b2;
    logic                   tbl_wr;

    // The byte that will be the newest window byte once the resolve stage has
    // shifted; when the window is cleared instead, no match is possible.
    assign eff_b2  = (r_s1_valid && (r_s1_cmd == CMD_DATA)) ? r_s1_byte : r_win[7:0];
    assign rd_addr = {eff_b2[2:0], in_byte[7:5]};
    assign tbl_wr  = in_acc && (i_s_axis_tuser == CMD_TABLE)
                     && ({1'b0, in_chan} < 7'(CHANNEL_COUNT));

    // Table write at command acceptance, read at data acceptance.
    always_ff @(posedge i_clk) begin
        if (tbl_wr) begin
            r_mem[in_chan] <= in_len;
        end
        if (in_acc && (i_s_axis_tuser == CMD_DATA)) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid   <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (tbl_wr) begin
                r_tvalid[in_chan] <= 1'b1;
            end
            if (in_acc && (i_s_axis_tuser == CMD_DATA)) begin
                r_rd_valid <= r_tvalid[rd_addr];
            end
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd  <= i_s_axis_tuser;
            r_s1_byte <= in_byte;
        end
    end

    // Resolve the staged data item against the window and the table entry.
    logic              push;
    t_entry            n_entry;
    logic              hdr_match;
    logic [CHAN_W-1:0] vcid;
    logic [LEN_W-1:0]  len_raw, len_sat;
    logic [23:0]       win_shift;

    assign vcid      = {r_win[2:0], r_s1_byte[7:5]};
    assign len_raw   = r_rd_valid ? r_rd_data : '0;
    assign len_sat   = (({1'b0, vcid} < 7'(CHANNEL_COUNT)) && (len_raw > MAX_LEN)) ? MAX_LEN
                       : (({1'b0, vcid} < 7'(CHANNEL_COUNT)) ? len_raw : '0);
    assign win_shift = {r_win[15:0], r_s1_byte};
    assign hdr_match = (r_fill == 2'd3)
                       && (r_win[23:16] == {r_fv, r_scid[15:12]})
                       && (r_win[15:8]  == r_scid[11:4])
                       && (r_win[7:4]   == r_scid[3:0]);

    always_comb begin
        n_win      = r_win;
        n_fill     = r_fill;
        n_in_frame = r_in_frame;
        n_left     = r_left;
        n_cur_ch   = r_cur_ch;
        push       = 1'b0;
        n_entry    = '0;
        if (r_s1_valid && (r_s1_cmd == CMD_DATA)) begin
            if (r_in_frame) begin
                // Pass one frame byte; the final one ends the frame.
                push           = 1'b1;
                n_entry.kind   = KIND_FRAME;
                n_entry.cnt_m1 = 2'd0;
                n_entry.chan   = r_cur_ch;
                n_entry.bytes[0] = r_s1_byte;
                n_entry.last   = (r_left <= LEN_W'(1));
                if (r_left <= LEN_W'(1)) begin
                    n_in_frame = 1'b0;
                    n_left     = '0;
                    n_win      = '0;
                    n_fill     = 2'd0;
                end else begin
                    n_left = r_left - LEN_W'(1);
                end
            end else if (!hdr_match) begin
                n_win  = win_shift;
                n_fill = (r_fill == 2'd3) ? 2'd3 : r_fill + 2'd1;
            end else if (len_sat < HDR_LEN) begin
                // Unknown channel or a length too short: report the skip and keep hunting.
                push           = 1'b1;
                n_entry.kind   = KIND_SKIP;
                n_entry.cnt_m1 = 2'd0;
                n_entry.chan   = vcid;
                n_entry.last   = 1'b1;
                n_win          = win_shift;
            end else begin
                // Header located: the four header bytes leave as one burst.
                push             = 1'b1;
                n_entry.kind     = KIND_FRAME;
                n_entry.cnt_m1   = 2'd3;
                n_entry.chan     = vcid;
                n_entry.bytes[0] = r_win[23:16];
                n_entry.bytes[1] = r_win[15:8];
                n_entry.bytes[2] = r_win[7:0];
                n_entry.bytes[3] = r_s1_byte;
                n_entry.last     = (len_sat == HDR_LEN);
                n_win            = '0;
                n_fill           = 2'd0;
                if (len_sat > HDR_LEN) begin
                    n_in_frame = 1'b1;
                    n_left     = len_sat - HDR_LEN;
                    n_cur_ch   = vcid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_fill     <= 2'd0;
            r_in_frame <= 1'b0;
            r_left     <= '0;
            r_cur_ch   <= '0;
        end else begin
            r_win      <= n_win;
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
            r_left     <= n_left;
            r_cur_ch   <= n_cur_ch;
        end
    end

    // Output queue with a burst serializer at its head.
    t_entry            r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [1:0]        r_idx;
    t_entry            head;
    logic              out_acc;
    logic              pop;

    assign head    = r_q[r_rd_ptr];
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign pop     = out_acc && (r_idx == head.cnt_m1);

    // Room for the staged item and for the one being accepted.
    assign o_s_axis_tready = (r_count + QCNT_W'(r_s1_valid)) < QCNT_W'(QDEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_idx    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
                r_idx    <= 2'd0;
            end else if (out_acc) begin
                r_idx <= r_idx + 2'd1;
            end
            r_count <= r_count + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {2'b00, head.chan, head.bytes[r_idx]};
    assign o_m_axis_tuser  = head.kind;
    assign o_m_axis_tlast  = head.last && (r_idx == head.cnt_m1);

    // Checks on queue accounting and frame state.
    `USLP_ASSERT_SAME(a_queue_bound, 1'b1, r_count <= QCNT_W'(QDEPTH),
        "output queue count exceeds depth")
    `USLP_ASSERT_SAME(a_no_overflow, push, (r_count < QCNT_W'(QDEPTH)) || pop,
        "push into a full output queue")
    `USLP_ASSERT_SAME(a_frame_window_empty, r_in_frame, r_fill == 2'd0,
        "hunting window not empty inside a frame")
    `USLP_ASSERT_SAME(a_skip_single, o_m_axis_tvalid && (o_m_axis_tuser == KIND_SKIP),
        o_m_axis_tlast && (o_m_axis_tdata[7:0] == 8'd0), "skip report not a single last item")
    `USLP_ASSERT_NEXT(a_burst_advance, out_acc && !pop, o_m_axis_tvalid && (r_idx != 2'd0),
        "header burst lost its head")

endmodule

// ===== test/uslp_frame_sync_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USLP frame sync checker
// Watches the configuration port and both streams, tracks the marker hunt,
// the length table and the frame in progress, and compares every output item
// field by field with the oldest byte still owed.
// ----------------------------------------------------------------------------
module uslp_frame_sync_checker
    import uslp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port, as seen by the block.
    input  logic                 i_cfg_wen,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    // [7:0] data_byte, [13:8] table_channel, [25:14] table_length, [31:26] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // [0] command
    input  logic                 i_s_axis_tuser,
    // Output stream.
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [7:0] frame_byte, [13:8] channel, [15:14] zero
    input  logic [M_TDATA_W-1:0] i_m_axis_tdata,
    // [0] kind
    input  logic                 i_m_axis_tuser,
    input  logic                 i_m_axis_tlast,
    // Status toward the testbench top.
    output int                   o_error_count,
    output int                   o_bytes_owed
);

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] fbyte;
        logic              last;
        logic [CHAN_W-1:0] chan;
    } t_sync_out;

    // Marker registers and synchronizer state.
    logic [FV_W-1:0]   exp_version;
    logic [SCID_W-1:0] exp_scid;
    logic [23:0]       hunt_window;
    logic [1:0]        hunt_fill;
    logic              framing;
    logic [LEN_W-1:0]  frame_left;
    logic [CHAN_W-1:0] frame_chan;
    logic [LEN_W-1:0]  chan_length [TABLE_DEPTH];

    t_sync_out         owed_q [$];
    int                errors = 0;

    task automatic owe_item(input logic kind, input logic [BYTE_W-1:0] fbyte,
                            input logic last, input logic [CHAN_W-1:0] chan);
        t_sync_out item;
        item.kind  = kind;
        item.fbyte = fbyte;
        item.last  = last;
        item.chan  = chan;
        owed_q.push_back(item);
    endtask

    task automatic hunt_shift(input logic [BYTE_W-1:0] b);
        hunt_window = {hunt_window[15:0], b};
        if (hunt_fill != 2'd3) begin
            hunt_fill = hunt_fill + 2'd1;
        end
    endtask

    // Works out what one accepted input item makes the block emit.
    task automatic follow_item(input logic cmd, input logic [BYTE_W-1:0] b,
                               input logic [CHAN_W-1:0] ch, input logic [LEN_W-1:0] len);
        logic [BYTE_W-1:0] h0;
        logic [BYTE_W-1:0] h1;
        logic [BYTE_W-1:0] h2;
        logic [CHAN_W-1:0] vc;
        logic [LEN_W-1:0]  flen;
        logic              closing;
        h0 = hunt_window[23:16];
        h1 = hunt_window[15:8];
        h2 = hunt_window[7:0];
        vc = {h2[2:0], b[7:5]};
        closing = (frame_left < LEN_W'(2));
        if (cmd == CMD_TABLE) begin
            // Table writes never disturb hunting or a frame under way.
            if (int'(ch) < CHANNEL_COUNT) begin
                chan_length[ch] = len;
            end
        end else if (framing) begin
            owe_item(KIND_FRAME, b, closing, frame_chan);
            if (closing) begin
                framing     = 1'b0;
                frame_left  = '0;
                hunt_window = '0;
                hunt_fill   = '0;
            end else begin
                frame_left = frame_left - LEN_W'(1);
            end
        end else if (hunt_fill != 2'd3
                     || h0 != {exp_version, exp_scid[15:12]}
                     || h1 != exp_scid[11:4]
                     || h2[7:4] != exp_scid[3:0]) begin
            hunt_shift(b);
        end else begin
            flen = (int'(vc) < CHANNEL_COUNT) ? chan_length[vc] : '0;
            if (flen > LEN_W'(MAX_FRAME_BYTES)) begin
                flen = LEN_W'(MAX_FRAME_BYTES);
            end
            if (flen < LEN_W'(HEADER_BYTES)) begin
                // Unknown channel or a length too short: report and keep hunting.
                owe_item(KIND_SKIP, '0, 1'b1, vc);
                hunt_shift(b);
            end else begin
                owe_item(KIND_FRAME, h0, 1'b0, vc);
                owe_item(KIND_FRAME, h1, 1'b0, vc);
                owe_item(KIND_FRAME, h2, 1'b0, vc);
                owe_item(KIND_FRAME, b, flen == LEN_W'(HEADER_BYTES), vc);
                hunt_window = '0;
                hunt_fill   = '0;
                if (flen > LEN_W'(HEADER_BYTES)) begin
                    framing    = 1'b1;
                    frame_left = flen - LEN_W'(HEADER_BYTES);
                    frame_chan = vc;
                end
            end
        end
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic match_output();
        t_sync_out want;
        if (owed_q.size() == 0) begin
            $display("%0t: output item with nothing owed, expected none, actual %0h/%0h/%0h/%0h",
                     $time, i_m_axis_tuser, i_m_axis_tdata[7:0], i_m_axis_tlast,
                     i_m_axis_tdata[13:8]);
            errors++;
        end else begin
            want = owed_q.pop_front();
            check_field("kind", 32'(want.kind), 32'(i_m_axis_tuser));
            check_field("frame_byte", 32'(want.fbyte), 32'(i_m_axis_tdata[7:0]));
            check_field("last_byte", 32'(want.last), 32'(i_m_axis_tlast));
            check_field("channel", 32'(want.chan), 32'(i_m_axis_tdata[13:8]));
        end
    endtask

    // Handshakes are sampled at the rising edge, before any driver updates.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            exp_version = FV_RESET;
            exp_scid    = SCID_RESET;
            hunt_window = '0;
            hunt_fill   = '0;
            framing     = 1'b0;
            frame_left  = '0;
            frame_chan  = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                chan_length[i] = '0;
            end
            owed_q.delete();
        end else begin
            if (i_cfg_wen) begin
                case (i_cfg_index)
                    REG_FRAME_VERSION: exp_version = i_cfg_wdata[FV_W-1:0];
                    REG_SPACECRAFT_ID: exp_scid    = i_cfg_wdata[SCID_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                follow_item(i_s_axis_tuser, i_s_axis_tdata[7:0], i_s_axis_tdata[13:8],
                            i_s_axis_tdata[25:14]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                match_output();
            end
        end
        o_bytes_owed  <= owed_q.size();
        o_error_count <= errors;
    end

endmodule

// ===== test/tb_uslp_frame_sync_vcid_length_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USLP frame sync testbench
// Drives marker settings, length table writes and byte streams with random
// gaps on both sides: a short directed run over the special cases, then
// random frames, noise and broken headers under several marker settings.
// ----------------------------------------------------------------------------
module tb_uslp_frame_sync_vcid_length_core
    import uslp_pkg::*;
();

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wen;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    // [7:0] data_byte, [13:8] table_channel, [25:14] table_length, [31:26] zero
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    // [0] command
    logic                 i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    // [7:0] frame_byte, [13:8] channel, [15:14] zero
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    // [0] kind
    logic                 o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    int error_count;
    int bytes_owed;

    // Stimulus-side view of the marker and of the lengths loaded so far.
    logic [FV_W-1:0]   fv_now;
    logic [SCID_W-1:0] scid_now;
    logic [LEN_W-1:0]  loaded_len [CHANNEL_COUNT];
    int                send_calm;
    int                recv_calm;
    int                items_sent;

    uslp_frame_sync_vcid_length_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    uslp_frame_sync_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tuser  (o_m_axis_tuser),
        .i_m_axis_tlast  (o_m_axis_tlast),
        .o_error_count   (error_count),
        .o_bytes_owed    (bytes_owed)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop in case the block hangs or withholds results.
    initial begin
        #2000000;
        $display("uslp_frame_sync_vcid_length_core test failed");
        $finish;
    end

    // Random wait before the next item, with calm stretches of back-to-back items.
    function automatic int next_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b,
                             input logic [CHAN_W-1:0] ch, input logic [LEN_W-1:0] len);
        int gap;
        gap = next_wait(send_calm);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {6'd0, len, ch, b};
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    // Unused table fields of a data item carry random values.
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        logic [CHAN_W-1:0] junk_ch;
        logic [LEN_W-1:0]  junk_len;
        junk_ch  = CHAN_W'($urandom_range(0, 63));
        junk_len = LEN_W'($urandom_range(0, 4095));
        send_item(CMD_DATA, b, junk_ch, junk_len);
    endtask

    task automatic load_len(input logic [CHAN_W-1:0] ch, input logic [LEN_W-1:0] len);
        logic [BYTE_W-1:0] junk;
        junk = BYTE_W'($urandom_range(0, 255));
        loaded_len[ch] = len;
        send_item(CMD_TABLE, junk, ch, len);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_marker(input logic [FV_W-1:0] fv, input logic [SCID_W-1:0] scid);
        write_reg(REG_FRAME_VERSION, {{(CFG_W - FV_W){1'b0}}, fv});
        write_reg(REG_SPACECRAFT_ID, scid);
        fv_now   = fv;
        scid_now = scid;
    endtask

    // Drops the input valid and lets every owed result and any table read drain.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (bytes_owed != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Four header bytes for the current marker, with random spare bits.
    function automatic logic [3:0][BYTE_W-1:0] header_bytes(input logic [CHAN_W-1:0] vc);
        logic [3:0][BYTE_W-1:0] hb;
        logic                   spare;
        logic [4:0]             tail;
        spare = 1'($urandom_range(0, 1));
        tail  = 5'($urandom_range(0, 31));
        hb[0] = {fv_now, scid_now[15:12]};
        hb[1] = scid_now[11:4];
        hb[2] = {scid_now[3:0], spare, vc[5:3]};
        hb[3] = {vc[2:0], tail};
        return hb;
    endfunction

    task automatic push_header(input logic [CHAN_W-1:0] vc);
        logic [3:0][BYTE_W-1:0] hb;
        hb = header_bytes(vc);
        for (int i = 0; i < HEADER_BYTES; i++) begin
            push_byte(hb[i]);
        end
    endtask

    function automatic int frame_len(input logic [CHAN_W-1:0] vc);
        if (loaded_len[vc] > LEN_W'(MAX_FRAME_BYTES)) begin
            return MAX_FRAME_BYTES;
        end
        return int'(loaded_len[vc]);
    endfunction

    // Mostly ordinary frame lengths, some header-only and some too short.
    function automatic logic [LEN_W-1:0] pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            return LEN_W'($urandom_range(0, 3));
        end
        if (roll < 30) begin
            return LEN_W'(HEADER_BYTES);
        end
        return LEN_W'($urandom_range(5, 24));
    endfunction

    // A header and the whole body its length calls for; table writes now and then.
    task automatic run_frame(input logic [CHAN_W-1:0] vc);
        int body;
        body = frame_len(vc) - HEADER_BYTES;
        push_header(vc);
        for (int i = 0; i < body; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                load_len(CHAN_W'($urandom_range(0, 63)), pick_len());
            end
            push_byte(BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic random_episode();
        int                     roll;
        int                     k;
        int                     j;
        int                     cut;
        logic [CHAN_W-1:0]      vc;
        logic [3:0][BYTE_W-1:0] hb;
        roll = $urandom_range(0, 99);
        vc   = CHAN_W'($urandom_range(0, 63));
        if (roll < 10) begin
            load_len(vc, pick_len());
        end else if (roll < 20) begin
            // Line noise between frames.
            repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
        end else if (roll < 26) begin
            // Header with one marker bit flipped.
            hb = header_bytes(vc);
            k = $urandom_range(0, 1);
            j = $urandom_range(0, 7);
            hb[k][j] = ~hb[k][j];
            for (int i = 0; i < HEADER_BYTES; i++) begin
                push_byte(hb[i]);
            end
        end else if (roll < 32) begin
            // Header cut short by a stray byte.
            hb  = header_bytes(vc);
            cut = $urandom_range(1, 3);
            for (int i = 0; i < cut; i++) begin
                push_byte(hb[i]);
            end
            push_byte(BYTE_W'($urandom_range(0, 255)));
        end else begin
            if (roll < 66) begin
                load_len(vc, pick_len());
            end
            run_frame(vc);
        end
    endtask

    // Output side: random stalls before each item.
    initial begin
        int stall;
        i_m_axis_tready <= 1'b0;
        recv_calm = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = next_wait(recv_calm);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Input side and verdict.
    initial begin
        int                     goal;
        logic [3:0][BYTE_W-1:0] hb;
        i_rst_n         <= 1'b0;
        i_cfg_wen       <= 1'b0;
        i_cfg_index     <= REG_FRAME_VERSION;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_DATA;
        fv_now     = FV_RESET;
        scid_now   = SCID_RESET;
        send_calm  = 0;
        items_sent = 0;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            loaded_len[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Header-only channel, a short frame on the top channel, a too-short length.
        load_len(6'd5, 12'd4);
        load_len(6'd63, 12'd7);
        load_len(6'd0, 12'd2);

        // Header-only frame with a table write inside the marker window.
        hb = header_bytes(6'd5);
        push_byte(hb[0]);
        push_byte(hb[1]);
        load_len(6'd9, 12'd1);
        push_byte(hb[2]);
        push_byte(hb[3]);

        // Frame with extreme body bytes and a table write between them.
        push_header(6'd63);
        push_byte(8'h00);
        load_len(6'd9, 12'd0);
        push_byte(8'hFF);
        push_byte(8'hA5);

        // Too-short length, then a never-loaded channel right behind it.
        push_header(6'd0);
        push_header(6'd33);

        // Random traffic under several marker settings, extremes first.
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: set_marker('0, '0);
                1: set_marker('1, '1);
                default: set_marker(FV_W'($urandom_range(0, 15)),
                                    SCID_W'($urandom_range(0, 65535)));
            endcase
            goal = items_sent + 40;
            while (items_sent < goal) begin
                random_episode();
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("uslp_frame_sync_vcid_length_core test passed");
        end else begin
            $display("uslp_frame_sync_vcid_length_core test failed");
        end
        $finish;
    end

endmodule
